// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pulse width capture design.
// Concurrent assertions clocked on the rising edge; compiled out under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked at every edge outside reset.
`define PWC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PWC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PWC_ASSERT(label, clk, rst_n, prop, msg)
`define PWC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- design/pwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_pkg
// Types, constants and helper functions for the pulse width capture block.
// ----------------------------------------------------------------------------
package pwc_pkg;

    // Capacity of the capture buffer in duration words.
    localparam int BUFFER_WORDS = 16384;
    // Word counter wide enough to hold BUFFER_WORDS itself.
    localparam int WC_W         = $clog2(BUFFER_WORDS + 1);

    localparam int DUR_W        = 15;
    localparam int IDX_W        = 14;
    localparam int TS_W         = 32;
    localparam int NOISE_W      = 32;
    localparam int CFG_IDX_W    = 1;

    // Opcodes.
    localparam logic [1:0] OP_EDGE   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;
    localparam logic [1:0] OP_STOP   = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_CAPTURE  = 2'd0;
    localparam logic [1:0] KIND_NOISE    = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_THR = 1'd1;

    localparam logic [DUR_W-1:0] IDLE_LIMIT_RST = 15'd12000;
    localparam logic [DUR_W-1:0] GLITCH_THR_RST = 15'd140;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [TS_W-1:0] timestamp;
        logic            pin_level;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic [DUR_W-1:0]   duration;
        logic               low_phase;
        logic [IDX_W-1:0]   word_index;
        logic [NOISE_W-1:0] noise_total;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [DUR_W-1:0] idle_limit;
        logic [DUR_W-1:0] glitch_threshold;
    } t_cfg;

    // Hand-over of computed results from the core to the output buffer.
    typedef struct packed {
        logic load;
        logic two;
    } t_load_ctl;

    typedef struct packed {
        logic can_load;
        logic pend;
    } t_obuf_status;

    function automatic logic [DUR_W-1:0] clamp_dur(input logic [TS_W-1:0]  d,
                                                   input logic [DUR_W-1:0] lim);
        logic [DUR_W-1:0] res;
        res = (d > TS_W'(lim)) ? lim : d[DUR_W-1:0];
        return res;
    endfunction

endpackage

// ----- design/pwc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_cfg_regs
// Configuration registers: clamp limit and glitch threshold.
// ----------------------------------------------------------------------------
module pwc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pwc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pwc_pkg::DUR_W-1:0]     i_cfg_data,
    output pwc_pkg::t_cfg                 o_cfg
);

    pwc_pkg::t_cfg r_cfg;
    pwc_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                pwc_pkg::CFG_IDLE_LIMIT: n_cfg.idle_limit       = i_cfg_data;
                pwc_pkg::CFG_GLITCH_THR: n_cfg.glitch_threshold = i_cfg_data;
                default:                 n_cfg                  = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_limit       <= pwc_pkg::IDLE_LIMIT_RST;
            r_cfg.glitch_threshold <= pwc_pkg::GLITCH_THR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- design/pwc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_core
// Input register, capture state and the single-pass edge evaluation that
// produces up to two result beats per item.
// ----------------------------------------------------------------------------
module pwc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pwc_pkg::t_in      i_in,
    input  pwc_pkg::t_cfg     i_cfg,
    input  logic              i_can_load,
    output pwc_pkg::t_load_ctl o_load,
    output pwc_pkg::t_out     o_res0,
    output pwc_pkg::t_out     o_res1
);

    localparam int WC_EXT_W = pwc_pkg::WC_W + 1;

    logic                          r_in_v;
    pwc_pkg::t_in                  r_in;

    logic [pwc_pkg::TS_W-1:0]      r_rise_time, n_rise_time;
    logic [pwc_pkg::TS_W-1:0]      r_fall_time, n_fall_time;
    logic [pwc_pkg::WC_W-1:0]      r_word_count, n_word_count;
    logic [pwc_pkg::NOISE_W-1:0]   r_noise_count, n_noise_count;
    logic                          r_capturing, n_capturing;

    logic [pwc_pkg::DUR_W-1:0]     low_d;
    logic [pwc_pkg::DUR_W-1:0]     high_d;
    logic [WC_EXT_W-1:0]           wc_p1;
    logic [WC_EXT_W-1:0]           wc_p2;
    logic                          fits;
    logic [1:0]                    res_cnt;
    logic                          fire;
    logic                          in_take;

    assign low_d  = pwc_pkg::clamp_dur(r_in.timestamp - r_fall_time, i_cfg.idle_limit);
    assign high_d = pwc_pkg::clamp_dur(r_fall_time - r_rise_time, i_cfg.idle_limit);
    assign wc_p1  = {1'b0, r_word_count} + WC_EXT_W'(1);
    assign wc_p2  = {1'b0, r_word_count} + WC_EXT_W'(2);
    assign fits   = (wc_p2 <= WC_EXT_W'(pwc_pkg::BUFFER_WORDS));

    always_comb begin
        n_rise_time   = r_rise_time;
        n_fall_time   = r_fall_time;
        n_word_count  = r_word_count;
        n_noise_count = r_noise_count;
        n_capturing   = r_capturing;
        o_res0        = '0;
        o_res1        = '0;
        res_cnt       = 2'd0;
        case (r_in.opcode)
            pwc_pkg::OP_START: begin
                if (!r_capturing) begin
                    n_word_count = '0;
                    n_capturing  = 1'b1;
                end
            end
            pwc_pkg::OP_STATUS: begin
                o_res0.kind        = pwc_pkg::KIND_NOISE;
                o_res0.noise_total = r_noise_count;
                o_res0.last        = 1'b1;
                res_cnt            = 2'd1;
                n_noise_count      = '0;
            end
            pwc_pkg::OP_STOP: begin
                if (r_capturing) begin
                    n_capturing  = 1'b0;
                    n_word_count = '0;
                end
            end
            pwc_pkg::OP_EDGE: begin
                if (r_capturing) begin
                    if (!r_in.pin_level) begin
                        n_fall_time = r_in.timestamp;
                    end else if (low_d < i_cfg.glitch_threshold) begin
                        // A short low pulse is a glitch: it merges into the high time.
                        n_noise_count = r_noise_count + pwc_pkg::NOISE_W'(1);
                    end else begin
                        n_rise_time = r_in.timestamp;
                        if (fits) begin
                            o_res0.kind       = pwc_pkg::KIND_CAPTURE;
                            o_res0.duration   = high_d;
                            o_res0.word_index = pwc_pkg::IDX_W'(r_word_count);
                            o_res1.kind       = pwc_pkg::KIND_CAPTURE;
                            o_res1.duration   = low_d;
                            o_res1.low_phase  = 1'b1;
                            o_res1.word_index = pwc_pkg::IDX_W'(wc_p1);
                            o_res1.last       = 1'b1;
                            res_cnt           = 2'd2;
                            n_word_count      = wc_p2[pwc_pkg::WC_W-1:0];
                        end else begin
                            o_res0.kind = pwc_pkg::KIND_OVERFLOW;
                            o_res0.last = 1'b1;
                            res_cnt     = 2'd1;
                            n_capturing = 1'b0;
                        end
                    end
                end
            end
            default: begin
                res_cnt = 2'd0;
            end
        endcase
    end

    // Items without results never wait for the output buffer.
    assign fire        = r_in_v && ((res_cnt == 2'd0) || i_can_load);
    assign o_load.load = fire && (res_cnt != 2'd0);
    assign o_load.two  = (res_cnt == 2'd2);
    assign o_in_stall  = r_in_v && !fire;
    assign in_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v        <= 1'b0;
            r_rise_time   <= '0;
            r_fall_time   <= '0;
            r_word_count  <= '0;
            r_noise_count <= '0;
            r_capturing   <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_v <= 1'b1;
            end else if (fire) begin
                r_in_v <= 1'b0;
            end
            if (fire) begin
                r_rise_time   <= n_rise_time;
                r_fall_time   <= n_fall_time;
                r_word_count  <= n_word_count;
                r_noise_count <= n_noise_count;
                r_capturing   <= n_capturing;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
    end

endmodule

// ----- design/pwc_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_out_buf
// Two-beat result register: the presented beat plus one waiting beat.
// ----------------------------------------------------------------------------
module pwc_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pwc_pkg::t_load_ctl    i_load,
    input  pwc_pkg::t_out         i_res0,
    input  pwc_pkg::t_out         i_res1,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output pwc_pkg::t_out         o_out,
    output pwc_pkg::t_obuf_status o_status
);

    logic          r_out_v, n_out_v;
    logic          r_pend_v, n_pend_v;
    pwc_pkg::t_out r_out;
    pwc_pkg::t_out r_pend;
    logic          out_take;

    assign out_take          = r_out_v && !i_out_stall;
    // New results go in only when both slots are free after this cycle.
    assign o_status.can_load = !r_pend_v && (!r_out_v || out_take);
    assign o_status.pend     = r_pend_v;
    assign o_out_valid       = r_out_v;
    assign o_out             = r_out;

    always_comb begin
        n_out_v  = r_out_v;
        n_pend_v = r_pend_v;
        if (i_load.load) begin
            n_out_v  = 1'b1;
            n_pend_v = i_load.two;
        end else if (out_take) begin
            n_out_v  = r_pend_v;
            n_pend_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_out  <= i_res0;
            r_pend <= i_res1;
        end else if (out_take) begin
            r_out  <= r_pend;
        end
    end

endmodule

// ----- design/pulse_width_capture.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_capture
// Pulse width capture with glitch filter for a receiver pin.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the input stall is low. Each item
// is registered, evaluated in a single pass against the capture state and its
// results are loaded into a two-beat output register, whose first beat is
// presented once the item has passed the input and the output register. A
// rising edge that yields two duration words occupies the output register for
// two beats, so the next item with results stalls until the second word is
// being taken; items with no result do not wait for the output register. An
// item with results waits in the input register until the output register is
// empty or being emptied and holds no second beat. A result-side stall
// therefore reaches the input stall as soon as one beat is held and an item
// with results is waiting in the input register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pulse_width_capture (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pwc_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pwc_pkg::t_out                 o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pwc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pwc_pkg::DUR_W-1:0]     i_cfg_data
);

    pwc_pkg::t_cfg         cfg;
    pwc_pkg::t_load_ctl    load_ctl;
    pwc_pkg::t_out         res0;
    pwc_pkg::t_out         res1;
    pwc_pkg::t_obuf_status obuf_status;

    pwc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pwc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_cfg      (cfg),
        .i_can_load (obuf_status.can_load),
        .o_load     (load_ctl),
        .o_res0     (res0),
        .o_res1     (res1)
    );

    pwc_out_buf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load_ctl),
        .i_res0      (res0),
        .i_res1      (res1),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .o_status    (obuf_status)
    );

    // A waiting second beat implies a presented beat.
    `PWC_ASSERT_ALWAYS(a_pend_needs_out, i_clk, obuf_status.pend |-> o_out_valid, "pending beat without valid output")

    // Only the high-phase capture word is ever delivered without last.
    `PWC_ASSERT(a_nonlast_is_high_word, i_clk, i_rst_n, (o_out_valid && !i_out_stall && !o_out.last) |-> (o_out.kind == pwc_pkg::KIND_CAPTURE && !o_out.low_phase), "non-final beat is not a high-phase word")

    // The low-phase word follows its high-phase word in the next cycle.
    `PWC_ASSERT(a_low_word_follows, i_clk, i_rst_n, (o_out_valid && !i_out_stall && !o_out.last) |=> (o_out_valid && o_out.kind == pwc_pkg::KIND_CAPTURE && o_out.low_phase && o_out.last), "low-phase word missing after high-phase word")

endmodule

// ----- tb/pulse_width_capture_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_capture_tb
// Self-checking bench for the pulse width capture block. Edge, start, stop and
// status beats are driven through the input channel while a local predictor
// of the capture state works out the expected result beats. Each result beat
// leaving the block is compared field by field with the oldest prediction.
// Directed tests cover the opcodes, wrap-around, glitch merging, extreme
// limits and a full buffer. Random phases then vary idling on both sides,
// and one test holds the output off long enough to fill the block.
// ----------------------------------------------------------------------------
module pulse_width_capture_tb;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 400;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    pwc_pkg::t_in                  in_beat   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    pwc_pkg::t_out                 out_beat;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [pwc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pwc_pkg::DUR_W-1:0]     cfg_data  = '0;

    // Predicted state of the block, reset values included.
    logic [pwc_pkg::DUR_W-1:0]   lim_ticks    = pwc_pkg::IDLE_LIMIT_RST;
    logic [pwc_pkg::DUR_W-1:0]   glitch_ticks = pwc_pkg::GLITCH_THR_RST;
    logic [pwc_pkg::TS_W-1:0]    rise_ts      = '0;
    logic [pwc_pkg::TS_W-1:0]    fall_ts      = '0;
    int                          words_held   = 0;
    logic [pwc_pkg::NOISE_W-1:0] noise_seen   = '0;
    logic                        cap_on       = 1'b0;

    pwc_pkg::t_out expected_results[$];

    int send_gap_pct   = 0;
    int out_stall_pct  = 0;
    int hold_asked     = 0;
    int hold_done      = 0;
    int hold_left      = 0;
    int quiet          = 0;
    int mismatches     = 0;
    int beats_sent     = 0;
    int beats_taken    = 0;
    int words_seen     = 0;
    int status_seen    = 0;
    int notices_seen   = 0;
    int settings_used  = 0;
    logic [pwc_pkg::TS_W-1:0] beat_ts = '0;

    pulse_width_capture u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [pwc_pkg::DUR_W-1:0] clamp_ticks(
            input logic [pwc_pkg::TS_W-1:0] d);
        return (d > pwc_pkg::TS_W'(lim_ticks)) ? lim_ticks : d[pwc_pkg::DUR_W-1:0];
    endfunction

    // Updates the predicted state for one accepted beat and queues its results.
    function automatic void predict_beat(input pwc_pkg::t_in b);
        logic [pwc_pkg::DUR_W-1:0] low_d;
        logic [pwc_pkg::DUR_W-1:0] high_d;
        logic                      ignored;
        pwc_pkg::t_out             r;
        ignored = 1'b0;
        r       = '0;
        case (b.opcode)
            pwc_pkg::OP_START: begin
                if (cap_on) begin
                    ignored = 1'b1;
                end else begin
                    words_held = 0;
                    cap_on     = 1'b1;
                end
            end
            pwc_pkg::OP_STATUS: begin
                r.kind        = pwc_pkg::KIND_NOISE;
                r.noise_total = noise_seen;
                r.last        = 1'b1;
                expected_results.push_back(r);
                noise_seen = '0;
            end
            pwc_pkg::OP_STOP: begin
                if (!cap_on) begin
                    ignored = 1'b1;
                end else begin
                    cap_on     = 1'b0;
                    words_held = 0;
                end
            end
            pwc_pkg::OP_EDGE: begin
                if (!cap_on) begin
                    ignored = 1'b1;
                end else if (!b.pin_level) begin
                    fall_ts = b.timestamp;
                end else begin
                    low_d = clamp_ticks(b.timestamp - fall_ts);
                    if (low_d < glitch_ticks) begin
                        // A glitch: the high phase simply carries on.
                        noise_seen = noise_seen + pwc_pkg::NOISE_W'(1);
                    end else begin
                        high_d  = clamp_ticks(fall_ts - rise_ts);
                        rise_ts = b.timestamp;
                        if (words_held + 2 <= pwc_pkg::BUFFER_WORDS) begin
                            r.kind       = pwc_pkg::KIND_CAPTURE;
                            r.duration   = high_d;
                            r.word_index = pwc_pkg::IDX_W'(words_held);
                            expected_results.push_back(r);
                            r.duration   = low_d;
                            r.low_phase  = 1'b1;
                            r.word_index = pwc_pkg::IDX_W'(words_held + 1);
                            r.last       = 1'b1;
                            expected_results.push_back(r);
                            words_held = words_held + 2;
                        end else begin
                            cap_on = 1'b0;
                            r.kind = pwc_pkg::KIND_OVERFLOW;
                            r.last = 1'b1;
                            expected_results.push_back(r);
                        end
                    end
                end
            end
            default: begin
                ignored = 1'b1;
            end
        endcase
        if (!ignored) beats_taken++;
    endfunction

    function automatic void report_mismatch(input string what, input pwc_pkg::t_out want,
                                             input pwc_pkg::t_out got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected kind=%0d dur=%0d low=%0b idx=%0d noise=%0d last=%0b",
                     $time, what, want.kind, want.duration, want.low_phase,
                     want.word_index, want.noise_total, want.last);
            $display("%0t: %s: actual   kind=%0d dur=%0d low=%0b idx=%0d noise=%0d last=%0b",
                     $time, what, got.kind, got.duration, got.low_phase,
                     got.word_index, got.noise_total, got.last);
        end
    endfunction

    // Result checker: every beat taken from the block is matched in order.
    always @(posedge clk) begin : check_result
        pwc_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            case (out_beat.kind)
                pwc_pkg::KIND_CAPTURE:  words_seen++;
                pwc_pkg::KIND_NOISE:    status_seen++;
                pwc_pkg::KIND_OVERFLOW: notices_seen++;
                default: ;
            endcase
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing expected", '0, out_beat);
            end else begin
                want = expected_results.pop_front();
                if (out_beat.kind !== want.kind || out_beat.duration !== want.duration ||
                    out_beat.low_phase !== want.low_phase ||
                    out_beat.word_index !== want.word_index ||
                    out_beat.noise_total !== want.noise_total ||
                    out_beat.last !== want.last) begin
                    report_mismatch("result beat differs", want, out_beat);
                end
            end
        end
    end

    // Receiver: a requested hold-off wins over the random stall rate.
    always @(posedge clk) begin
        if (hold_asked != hold_done) begin
            hold_done <= hold_asked;
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("no beat moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Leaves valid high on acceptance; the next call or settle decides.
    task automatic send_item(input logic [1:0] op, input logic [pwc_pkg::TS_W-1:0] ts,
                             input logic lvl);
        pwc_pkg::t_in b;
        b.opcode    = op;
        b.timestamp = ts;
        b.pin_level = lvl;
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
        predict_beat(b);
    endtask

    task automatic send_op(input logic [1:0] op);
        send_item(op, $urandom, 1'($urandom_range(1)));
    endtask

    // One falling and one rising edge, each after the given span.
    task automatic send_pulse(input logic [pwc_pkg::TS_W-1:0] high_span,
                              input logic [pwc_pkg::TS_W-1:0] low_span);
        beat_ts = beat_ts + high_span;
        send_item(pwc_pkg::OP_EDGE, beat_ts, 1'b0);
        beat_ts = beat_ts + low_span;
        send_item(pwc_pkg::OP_EDGE, beat_ts, 1'b1);
    endtask

    // Items with no result may still be in flight when the queue empties.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pwc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pwc_pkg::DUR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == pwc_pkg::CFG_IDLE_LIMIT) lim_ticks = val;
        else glitch_ticks = val;
    endtask

    task automatic set_limits(input logic [pwc_pkg::DUR_W-1:0] lim,
                              input logic [pwc_pkg::DUR_W-1:0] thr);
        write_reg(pwc_pkg::CFG_IDLE_LIMIT, lim);
        write_reg(pwc_pkg::CFG_GLITCH_THR, thr);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [pwc_pkg::TS_W-1:0] pick_span();
        case ($urandom_range(9))
            0:       return $urandom;
            1, 2:    return pwc_pkg::TS_W'($urandom_range(32'(glitch_ticks)));
            3:       return pwc_pkg::TS_W'(glitch_ticks) + pwc_pkg::TS_W'($urandom_range(2));
            default: return pwc_pkg::TS_W'($urandom_range(2 * 32'(lim_ticks) + 16));
        endcase
    endfunction

    task automatic test_opcodes();
        send_op(pwc_pkg::OP_STATUS);
        send_item(pwc_pkg::OP_EDGE, 32'hFFFF_FFFF, 1'b1);
        send_op(pwc_pkg::OP_STOP);
        send_op(pwc_pkg::OP_START);
        send_op(pwc_pkg::OP_START);
        // The first high phase runs from a rise time of zero and clamps.
        send_item(pwc_pkg::OP_EDGE, 32'hFFFF_FF00, 1'b0);
        send_item(pwc_pkg::OP_EDGE, 32'h0000_0010, 1'b1);
        send_item(pwc_pkg::OP_EDGE, 32'h0000_0020, 1'b0);
        send_item(pwc_pkg::OP_EDGE, 32'h0000_0020 + 32'd100, 1'b1);
        send_item(pwc_pkg::OP_EDGE, 32'h0000_0020 + 32'(pwc_pkg::GLITCH_THR_RST) - 1, 1'b1);
        send_item(pwc_pkg::OP_EDGE, 32'h0000_0020 + 32'(pwc_pkg::GLITCH_THR_RST), 1'b1);
        send_item(pwc_pkg::OP_EDGE, 32'h0000_0000, 1'b0);
        send_item(pwc_pkg::OP_EDGE, 32'h0000_0000, 1'b1);
        send_op(pwc_pkg::OP_STATUS);
        send_op(pwc_pkg::OP_STATUS);
        send_item(pwc_pkg::OP_EDGE, 32'hFFFF_FFFF, 1'b0);
        send_item(pwc_pkg::OP_EDGE, 32'hFFFF_FFFF + 32'd20000, 1'b1);
        send_op(pwc_pkg::OP_STOP);
        send_op(pwc_pkg::OP_STATUS);
        settle();
    endtask

    task automatic test_extreme_limits();
        // A zero limit clamps everything to zero; no threshold keeps the words.
        set_limits('0, '0);
        send_op(pwc_pkg::OP_START);
        send_pulse($urandom, $urandom);
        send_pulse(1, 0);
        send_op(pwc_pkg::OP_STOP);
        settle();
        set_limits('1, '1);
        send_op(pwc_pkg::OP_START);
        send_pulse(32'd40000, 32'd40000);
        send_pulse(32'd5, 32'd32766);
        send_pulse(32'd5, 32'd32767);
        send_op(pwc_pkg::OP_STATUS);
        send_op(pwc_pkg::OP_STOP);
        settle();
        // Limit below the threshold: every low phase is a glitch.
        set_limits(15'd1, '1);
        send_op(pwc_pkg::OP_START);
        send_pulse(32'd300, 32'd300);
        send_pulse(32'd300, 32'd0);
        send_op(pwc_pkg::OP_STATUS);
        send_op(pwc_pkg::OP_STOP);
        settle();
    endtask

    task automatic test_buffer_full();
        set_limits('1, '0);
        out_stall_pct = 20;
        send_op(pwc_pkg::OP_START);
        for (int k = 0; k < pwc_pkg::BUFFER_WORDS / 2; k++) begin
            send_pulse($urandom_range(1, 40000), $urandom_range(1, 40000));
        end
        // No room for two more words: capture ends with a notice.
        send_pulse(32'd1000, 32'd1000);
        send_pulse(32'd1000, 32'd1000);
        send_op(pwc_pkg::OP_STOP);
        send_op(pwc_pkg::OP_START);
        send_pulse(32'd700, 32'd900);
        send_op(pwc_pkg::OP_STOP);
        settle();
    endtask

    task automatic test_random_phase(input logic [pwc_pkg::DUR_W-1:0] lim,
                                     input logic [pwc_pkg::DUR_W-1:0] thr,
                                     input int gap_pct, input int stall_pct,
                                     input int target);
        int goal;
        int pick;
        set_limits(lim, thr);
        send_gap_pct  = gap_pct;
        out_stall_pct = stall_pct;
        goal = beats_taken + target;
        while (beats_taken < goal) begin
            pick = $urandom_range(99);
            if (!cap_on && pick < 85) send_op(pwc_pkg::OP_START);
            else if (pick < 3) send_op(pwc_pkg::OP_START);
            else if (pick < 6) send_op(pwc_pkg::OP_STOP);
            else if (pick < 10) send_op(pwc_pkg::OP_STATUS);
            else if (pick < 17) send_item(pwc_pkg::OP_EDGE, $urandom, 1'($urandom_range(1)));
            else if (pick < 19) beat_ts = $urandom;
            else send_pulse(pick_span(), pick_span());
        end
        settle();
    endtask

    task automatic test_backpressure();
        send_gap_pct  = 0;
        out_stall_pct = 0;
        send_op(pwc_pkg::OP_START);
        // The receiver holds off while pulses keep coming, so the input stalls.
        hold_asked++;
        for (int k = 0; k < 50; k++) begin
            send_pulse($urandom_range(1, 20000), $urandom_range(200, 20000));
        end
        send_op(pwc_pkg::OP_STOP);
        settle();
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_opcodes();
        test_extreme_limits();
        test_buffer_full();
        test_random_phase(15'd12000, 15'd140, 0, 0, 160);
        test_random_phase(15'd300, 15'd60, 55, 0, 160);
        test_random_phase('1, '0, 0, 55, 160);
        test_random_phase(15'd5000, 15'd1000, 30, 30, 160);
        set_limits(pwc_pkg::IDLE_LIMIT_RST, pwc_pkg::GLITCH_THR_RST);
        test_backpressure();
        settle();
        $display("%0d input beats sent, %0d took effect, %0d limit settings applied",
                 beats_sent, beats_taken, settings_used);
        $display("%0d duration words, %0d noise reports, %0d overflow notices checked",
                 words_seen, status_seen, notices_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatching result beats", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/pwc_pkg.sv
design/pwc_cfg_regs.sv
design/pwc_core.sv
design/pwc_out_buf.sv
design/pulse_width_capture.sv
tb/pulse_width_capture_tb.sv
